// ===== sv/mnms_pkg.sv =====
// Shared constants, register codes and types for the neighbor majority smoother.
package mnms_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 128;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int IROW_W  = $clog2(MAX_ROWS + 2);
  localparam int SZC_W   = $clog2(MAX_COLS + 1);
  localparam int SZR_W   = $clog2(MAX_ROWS + 1);
  localparam int SIZE_W  = 8;
  localparam int LIM_W   = 4;
  localparam int POS_W   = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int WIN_W   = 9;
  localparam int LINE_W  = 2;

  localparam logic [SIZE_W-1:0] GRID_ROWS_RST = SIZE_W'(128);
  localparam logic [SIZE_W-1:0] GRID_COLS_RST = SIZE_W'(128);
  localparam logic [LIM_W-1:0]  CLEAR_MAX_RST = LIM_W'(3);
  localparam logic [LIM_W-1:0]  SET_MIN_RST   = LIM_W'(6);

  localparam logic [WIN_W-1:0] WIN_LEFT   = 9'h007;
  localparam logic [WIN_W-1:0] WIN_RIGHT  = 9'h1C0;
  localparam logic [WIN_W-1:0] WIN_TOP    = 9'h049;
  localparam logic [WIN_W-1:0] WIN_BOTTOM = 9'h124;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 4'd0,
    CFG_GRID_COLS = 4'd1,
    CFG_CLEAR_MAX = 4'd2,
    CFG_SET_MIN   = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              we;
    logic [COL_W-1:0]  waddr;
    logic [LINE_W-1:0] wdata;
    logic [COL_W-1:0]  raddr;
  } line_req_t;

endpackage

// ===== sv/mnms_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mnms_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mnms_line_store.sv =====
// Two row buffers in one RAM, with per-column valid bits and write-to-read forwarding.
module mnms_line_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mnms_pkg::line_req_t       req_i,
  output logic [mnms_pkg::LINE_W-1:0] rd_o
);
  import mnms_pkg::*;

  logic [MAX_COLS-1:0] valid_q;
  logic                rd_vld_q;
  logic                fwd_q;
  logic [LINE_W-1:0]   fwd_data_q;
  logic [LINE_W-1:0]   ram_rdata;
  logic                hit;

  mnms_ram #(
    .Width(LINE_W),
    .Depth(MAX_COLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  assign hit = req_i.we && (req_i.waddr == req_i.raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rd_vld_q <= valid_q[req_i.raddr];
      fwd_q    <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= req_i.wdata;
  end

  assign rd_o = fwd_q ? fwd_data_q : (rd_vld_q ? ram_rdata : '0);

endmodule

// ===== sv/mnms_cell_rule.sv =====
// Neighbor count over the masked 3x3 window and the clear, set or keep decision.
module mnms_cell_rule (
  input  logic [mnms_pkg::WIN_W-1:0] win_i,
  input  logic [mnms_pkg::LIM_W-1:0] clear_max_i,
  input  logic [mnms_pkg::LIM_W-1:0] set_min_i,
  output logic                       cell_o
);
  import mnms_pkg::*;

  logic [LIM_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int k = 0; k < WIN_W; k++) begin
      if (k != 4) begin
        cnt = cnt + LIM_W'(win_i[k]);
      end
    end
  end

  always_comb begin
    if (cnt <= clear_max_i) begin
      cell_o = 1'b0;
    end else if (cnt >= set_min_i) begin
      cell_o = 1'b1;
    end else begin
      cell_o = win_i[4];
    end
  end

endmodule

// ===== sv/moore_neighbor_majority_smoother.sv =====
// Top level of the streaming 3x3 majority smoother for binary grids.
// The grid enters one cell per request on the input channel in raster order.
// Each result carries the smoothed cell with its row and column and a flag on
// the last cell of the grid. Sizes and the two limits are set through the
// configuration channel, which is always ready; a write to a known register
// drops any grid in progress. A request is held in an input register and is
// processed from there into the output register, so a result shows on the
// output once the request that completes its neighborhood has passed both.
// A cell's result needs grid_cols + 1 later requests; after the last cell the
// host sends grid_cols + 1 flush requests to drain. One request is taken in
// every cycle; the single-port-read row RAM is read one column ahead.
// While the receiver stalls a full output register, processing stops and the
// input channel takes at most one more request. Reset clears the counters,
// the window, the row valid bits and both channel valid flags, and loads the
// register defaults of 128 rows, 128 columns and limits 3 and 6.
module moore_neighbor_majority_smoother (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mnms_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mnms_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cell_in_i,
  input  logic                               is_flush_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               cell_out_o,
  output logic [mnms_pkg::POS_W-1:0]         out_row_o,
  output logic [mnms_pkg::POS_W-1:0]         out_col_o,
  output logic                               grid_done_o
);
  import mnms_pkg::*;

  logic [SIZE_W-1:0] grid_rows_q, grid_cols_q;
  logic [LIM_W-1:0]  clear_max_q, set_min_q;
  logic [SZR_W-1:0]  rows_c;
  logic [SZC_W-1:0]  cols_c;

  logic              in_vld_q, in_vld_d;
  logic              cell_q, flush_q;
  logic              out_vld_q, out_vld_d;
  logic              cell_out_q;
  logic [POS_W-1:0]  out_row_q, out_col_q;
  logic              grid_done_q;

  logic [IROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  orow_q, orow_d;
  logic [COL_W-1:0]  ocol_q, ocol_d;
  logic [WIN_W-1:0]  win_q, win_d;

  logic              cfg_we, cfg_hit;
  logic              out_free, proc, idle_flush, act, produce, done;
  logic              v, last_icol, last_ocol, last_orow;
  logic [LINE_W-1:0] line_rd;
  logic [2:0]        newcol;
  logic [WIN_W-1:0]  shifted, win_sel, win_m;
  logic              res;
  line_req_t         line_req;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    if (grid_rows_q == '0) begin
      rows_c = SZR_W'(1);
    end else if (int'(grid_rows_q) > MAX_ROWS) begin
      rows_c = SZR_W'(MAX_ROWS);
    end else begin
      rows_c = SZR_W'(grid_rows_q);
    end
    if (grid_cols_q == '0) begin
      cols_c = SZC_W'(1);
    end else if (int'(grid_cols_q) > MAX_COLS) begin
      cols_c = SZC_W'(MAX_COLS);
    end else begin
      cols_c = SZC_W'(grid_cols_q);
    end
  end

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_idx_e'(cfg_index_i))
      CFG_GRID_ROWS: cfg_hit = cfg_we;
      CFG_GRID_COLS: cfg_hit = cfg_we;
      CFG_CLEAR_MAX: cfg_hit = cfg_we;
      CFG_SET_MIN:   cfg_hit = cfg_we;
      default:       cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GRID_ROWS_RST;
      grid_cols_q <= GRID_COLS_RST;
      clear_max_q <= CLEAR_MAX_RST;
      set_min_q   <= SET_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_ROWS: grid_rows_q <= cfg_data_i[SIZE_W-1:0];
        CFG_GRID_COLS: grid_cols_q <= cfg_data_i[SIZE_W-1:0];
        CFG_CLEAR_MAX: clear_max_q <= cfg_data_i[LIM_W-1:0];
        CFG_SET_MIN:   set_min_q   <= cfg_data_i[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free   = !out_vld_q || out_ready_i;
  assign proc       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || proc;

  assign idle_flush = flush_q && (row_q == '0) && (col_q == '0) &&
                      (orow_q == '0) && (ocol_q == '0);
  assign act        = proc && !idle_flush;

  assign v       = (flush_q || (row_q >= IROW_W'(rows_c))) ? 1'b0 : cell_q;
  assign newcol  = {v, line_rd[0], line_rd[1]};
  assign shifted = {newcol, win_q[WIN_W-1:3]};
  assign win_sel = (col_q == '0) ? {3'b000, win_q[WIN_W-1:3]} : shifted;

  assign produce = act && ((row_q > IROW_W'(1)) ||
                           ((row_q == IROW_W'(1)) && (col_q != '0)));

  assign last_icol = (SZC_W'(col_q) == (cols_c - SZC_W'(1)));
  assign last_ocol = (SZC_W'(ocol_q) == (cols_c - SZC_W'(1)));
  assign last_orow = (SZR_W'(orow_q) == (rows_c - SZR_W'(1)));
  assign done      = last_orow && last_ocol;

  always_comb begin
    win_m = win_sel;
    if (ocol_q == '0) begin
      win_m = win_m & ~WIN_LEFT;
    end
    if (last_ocol) begin
      win_m = win_m & ~WIN_RIGHT;
    end
    if (orow_q == '0) begin
      win_m = win_m & ~WIN_TOP;
    end
    if (last_orow) begin
      win_m = win_m & ~WIN_BOTTOM;
    end
  end

  mnms_cell_rule u_rule (
    .win_i       (win_m),
    .clear_max_i (clear_max_q),
    .set_min_i   (set_min_q),
    .cell_o      (res)
  );

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    orow_d = orow_q;
    ocol_d = ocol_q;
    win_d  = win_q;
    if (cfg_hit) begin
      row_d  = '0;
      col_d  = '0;
      orow_d = '0;
      ocol_d = '0;
      win_d  = '0;
    end else if (act) begin
      win_d = shifted;
      if (produce && done) begin
        row_d  = '0;
        col_d  = '0;
        orow_d = '0;
        ocol_d = '0;
        win_d  = '0;
      end else begin
        if (produce) begin
          if (last_ocol) begin
            ocol_d = '0;
            orow_d = orow_q + ROW_W'(1);
          end else begin
            ocol_d = ocol_q + COL_W'(1);
          end
        end
        if (last_icol) begin
          col_d = '0;
          row_d = row_q + IROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_comb begin
    line_req.we    = act;
    line_req.waddr = col_q;
    line_req.wdata = {line_rd[0], v};
    line_req.raddr = col_d;
  end

  mnms_line_store u_lines (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (line_req),
    .rd_o   (line_rd)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (produce) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      win_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      row_q     <= row_d;
      col_q     <= col_d;
      orow_q    <= orow_d;
      ocol_q    <= ocol_d;
      win_q     <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cell_q  <= cell_in_i;
      flush_q <= is_flush_i;
    end
    if (produce) begin
      cell_out_q  <= res;
      out_row_q   <= POS_W'(orow_q);
      out_col_q   <= POS_W'(ocol_q);
      grid_done_q <= done;
    end
  end

  assign out_valid_o = out_vld_q;
  assign cell_out_o  = cell_out_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign grid_done_o = grid_done_q;

endmodule

// ===== sv/mnms_checker.sv =====
// Port-level checks for the neighbor majority smoother and their binding to it.
module mnms_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [mnms_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [mnms_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            cell_in_i,
  input logic                            is_flush_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            cell_out_o,
  input logic [mnms_pkg::POS_W-1:0]      out_row_o,
  input logic [mnms_pkg::POS_W-1:0]      out_col_o,
  input logic                            grid_done_o
);
  import mnms_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_out_o) &&
      $stable(out_row_o) && $stable(out_col_o) && $stable(grid_done_o))
    else $error("Stalled result request changed or dropped.");

  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("Result request shown right after reset.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && grid_done_o |=> !out_valid_o)
    else $error("Result request directly after the last cell of a grid.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !grid_done_o) ##1 out_valid_o |->
      (out_col_o == $past(out_col_o) + POS_W'(1)) || (out_col_o == '0))
    else $error("Result columns out of raster order.");

endmodule

bind moore_neighbor_majority_smoother mnms_checker u_mnms_checker (.*);
